// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the octree point locate controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/octpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpl_pkg
// Constants, payload types and controller/datapath signal groups for the
// octree point locate block.
// ----------------------------------------------------------------------------
package octpl_pkg;

   localparam int NODE_CAPACITY = 4096;
   localparam int MAX_LEVELS    = 16;

   localparam int MASK_W   = 8;
   localparam int FC_W     = 12;
   localparam int COORD_W  = 32;
   localparam int FOUND_W  = 12;
   localparam int LEVELS_W = 5;
   localparam int STATUS_W = 2;

   localparam int NODE_AW  = $clog2(NODE_CAPACITY);
   localparam int CNT_W    = $clog2(NODE_CAPACITY + 1);
   localparam int CHILD_W  = ((FC_W > NODE_AW) ? FC_W : NODE_AW) + 1;
   localparam int CMP_W    = (CHILD_W > CNT_W) ? CHILD_W : CNT_W;
   localparam int LVL_W    = $clog2(MAX_LEVELS + 1);
   localparam int BELOW_W  = $clog2(MASK_W);
   localparam int LEVELS_SAT = (2 ** LEVELS_W) - 1;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_LOCATE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_LIMIT = 2'd2
   } status_type;

   typedef struct packed {
      logic [MASK_W-1:0]         mask;
      logic [FC_W-1:0]           first_child;
      logic signed [COORD_W-1:0] low_x;
      logic signed [COORD_W-1:0] low_y;
      logic signed [COORD_W-1:0] low_z;
      logic signed [COORD_W-1:0] high_x;
      logic signed [COORD_W-1:0] high_y;
      logic signed [COORD_W-1:0] high_z;
   } node_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic       append_write;
      logic       locate_start;
      logic       node_load;
      logic       descend;
      logic       scan_step;
      logic       status_set;
      status_type status_code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic rem_empty;
      logic child_in_range;
      logic box_hit;
      logic at_limit;
      logic rsp_free;
   } stat_type;

   function automatic logic [LEVELS_W-1:0] sat_levels(input logic [LVL_W-1:0] v);
      logic [LEVELS_W-1:0] r;
      if (32'(v) > 32'(LEVELS_SAT)) begin
         r = LEVELS_W'(LEVELS_SAT);
      end else begin
         r = LEVELS_W'(v);
      end
      return r;
   endfunction

endpackage

// File: hdl/octpl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpl_req_if
// Request channel: append node entries and locate points.
// ----------------------------------------------------------------------------
interface octpl_req_if;
   import octpl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [MASK_W-1:0]         octant_mask;
   logic [FC_W-1:0]           first_child;
   logic signed [COORD_W-1:0] low_x;
   logic signed [COORD_W-1:0] low_y;
   logic signed [COORD_W-1:0] low_z;
   logic signed [COORD_W-1:0] high_x;
   logic signed [COORD_W-1:0] high_y;
   logic signed [COORD_W-1:0] high_z;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;

   modport source (
      output valid, mode, octant_mask, first_child, low_x, low_y, low_z,
             high_x, high_y, high_z, point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, mode, octant_mask, first_child, low_x, low_y, low_z,
             high_x, high_y, high_z, point_x, point_y, point_z,
      output ready
   );
endinterface

// File: hdl/octpl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpl_rsp_if
// Response channel: one locate result per transaction.
// ----------------------------------------------------------------------------
interface octpl_rsp_if;
   import octpl_pkg::*;

   logic                valid;
   logic                ready;
   logic [FOUND_W-1:0]  found_node;
   logic [LEVELS_W-1:0] levels_walked;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, found_node, levels_walked, status,
      input  ready
   );
   modport sink (
      input  valid, found_node, levels_walked, status,
      output ready
   );
endinterface

// File: hdl/octpl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpl_ctrl
// Walk sequencer: accepts requests and steps the datapath through the tree.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module octpl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   output logic               req_ready,
   output octpl_pkg::cmd_type cmd,
   input  octpl_pkg::stat_type stat
);
   import octpl_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_ROOT_WAIT  = 6'b000010,
      ST_CHECK      = 6'b000100,
      ST_SCAN       = 6'b001000,
      ST_CHILD_WAIT = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_LOCATE) begin
                  cmd.locate_start = 1'b1;
                  if (stat.count_zero) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = STATUS_EMPTY;
                     state_in        = ST_FINISH;
                  end else begin
                     state_in = ST_ROOT_WAIT;
                  end
               end else begin
                  cmd.append_write = 1'b1;
               end
            end
         end
         ST_ROOT_WAIT: begin
            cmd.node_load = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            // leaf first, then level limit
            if (stat.rem_empty) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STATUS_OK;
               state_in        = ST_FINISH;
            end else if (stat.at_limit) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STATUS_LIMIT;
               state_in        = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.rem_empty) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STATUS_OK;
               state_in        = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.child_in_range) begin
                  state_in = ST_CHILD_WAIT;
               end
            end
         end
         ST_CHILD_WAIT: begin
            if (stat.box_hit) begin
               cmd.descend = 1'b1;
               state_in    = ST_CHECK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, stat.rsp_free, "result overwritten")
   `ASSERT_NEXT(a_empty_goes_finish, clock, reset, cmd.locate_start && stat.count_zero, state_ff == ST_FINISH, "empty locate did not finish")
   `ASSERT_NEXT(a_read_waits_child, clock, reset, cmd.scan_step && stat.child_in_range, state_ff == ST_CHILD_WAIT, "child read not followed")
   `ASSERT_IMPL(a_descend_on_hit, clock, reset, cmd.descend, state_ff == ST_CHILD_WAIT && stat.box_hit, "descend without hit")

endmodule

// File: hdl/octpl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpl_datapath
// Node memory, walk registers, box test and result register.
// ----------------------------------------------------------------------------
module octpl_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  octpl_pkg::node_type               req_node,
   input  octpl_pkg::point_type              req_point,
   input  octpl_pkg::cmd_type                cmd,
   output octpl_pkg::stat_type               stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [octpl_pkg::FOUND_W-1:0]     rsp_found_node,
   output logic [octpl_pkg::LEVELS_W-1:0]    rsp_levels_walked,
   output logic [octpl_pkg::STATUS_W-1:0]    rsp_status
);
   import octpl_pkg::*;

   node_type mem [NODE_CAPACITY];
   node_type rdata_ff;

   logic [CNT_W-1:0]   count_ff;
   point_type          point_ff;
   logic [NODE_AW-1:0] cur_ff;
   logic [LVL_W-1:0]   levels_ff;
   logic [MASK_W-1:0]  rem_ff;
   logic [FC_W-1:0]    fc_ff;
   logic [BELOW_W-1:0] below_ff;
   logic [CHILD_W-1:0] child_ff;
   status_type         status_ff;

   logic                rsp_valid_ff;
   logic [FOUND_W-1:0]  found_ff;
   logic [LEVELS_W-1:0] lvl_out_ff;
   status_type          stat_out_ff;

   logic [CHILD_W-1:0] child;
   logic               count_full;
   logic               rd_en;
   logic [NODE_AW-1:0] rd_addr;

   assign child      = CHILD_W'(fc_ff) + CHILD_W'(below_ff);
   assign count_full = (count_ff == CNT_W'(NODE_CAPACITY));
   assign rd_en      = cmd.locate_start | (cmd.scan_step & stat.child_in_range);
   assign rd_addr    = cmd.locate_start ? '0 : child[NODE_AW-1:0];

   always_comb begin
      stat.count_zero     = (count_ff == '0);
      stat.rem_empty      = (rem_ff == '0);
      stat.child_in_range = (CMP_W'(child) < CMP_W'(count_ff));
      stat.box_hit        = (rdata_ff.low_x <= point_ff.x) && (point_ff.x < rdata_ff.high_x) &&
                            (rdata_ff.low_y <= point_ff.y) && (point_ff.y < rdata_ff.high_y) &&
                            (rdata_ff.low_z <= point_ff.z) && (point_ff.z < rdata_ff.high_z);
      stat.at_limit       = (levels_ff >= LVL_W'(MAX_LEVELS));
      stat.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

   // node memory: write at the fill count, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append_write && !count_full) begin
         mem[count_ff[NODE_AW-1:0]] <= req_node;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.append_write && !count_full) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.locate_start) begin
         point_ff  <= req_point;
         cur_ff    <= '0;
         levels_ff <= '0;
      end
      if (cmd.node_load || cmd.descend) begin
         rem_ff   <= rdata_ff.mask;
         fc_ff    <= rdata_ff.first_child;
         below_ff <= '0;
      end
      if (cmd.descend) begin
         cur_ff    <= child_ff[NODE_AW-1:0];
         levels_ff <= levels_ff + LVL_W'(1);
      end
      // consume the lowest remaining child
      if (cmd.scan_step) begin
         rem_ff   <= rem_ff & (rem_ff - MASK_W'(1));
         below_ff <= below_ff + BELOW_W'(1);
         child_ff <= child;
      end
      if (cmd.status_set) begin
         status_ff <= cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         found_ff    <= FOUND_W'(cur_ff);
         lvl_out_ff  <= sat_levels(levels_ff);
         stat_out_ff <= status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found_node    = found_ff;
   assign rsp_levels_walked = lvl_out_ff;
   assign rsp_status        = stat_out_ff;

endmodule

// File: hdl/octree_point_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octree_point_locate
// Octree node table with point location walk from the root.
// ----------------------------------------------------------------------------
// Channel   Dir  Moves
// req_chan  in   append node entry (mode 0) or locate point (mode 1)
// rsp_chan  out  found node, levels walked, status (one per locate)
//
// An append is taken while idle. A locate reads the root, then per level
// checks the node and scans its children one at a time, reading each one
// inside the table through the single read port of the node memory; it
// descends into the first whose box holds the point, else it ends there.
// Synchronous active-high reset clears the fill count and the walk control;
// the node memory is not cleared. A finished result waits in the output
// register; a new request is taken once the walk has handed off its result.
// ----------------------------------------------------------------------------
module octree_point_locate (
   input  logic         clock,
   input  logic         reset,
   octpl_req_if.sink    req_chan,
   octpl_rsp_if.source  rsp_chan
);
   import octpl_pkg::*;

   cmd_type   cmd;
   stat_type  stat;
   node_type  req_node;
   point_type req_point;

   always_comb begin
      req_node.mask        = req_chan.octant_mask;
      req_node.first_child = req_chan.first_child;
      req_node.low_x       = req_chan.low_x;
      req_node.low_y       = req_chan.low_y;
      req_node.low_z       = req_chan.low_z;
      req_node.high_x      = req_chan.high_x;
      req_node.high_y      = req_chan.high_y;
      req_node.high_z      = req_chan.high_z;
      req_point.x          = req_chan.point_x;
      req_point.y          = req_chan.point_y;
      req_point.z          = req_chan.point_z;
   end

   octpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   octpl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_node          (req_node),
      .req_point         (req_point),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_found_node    (rsp_chan.found_node),
      .rsp_levels_walked (rsp_chan.levels_walked),
      .rsp_status        (rsp_chan.status)
   );

endmodule

// File: verif/octree_point_locate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octree_point_locate_tb
// Self-checking bench for the octree point locate block. A random octree is
// laid out up front with most children placed at later table indices, so the walk
// deepens as the table is appended. Locate points are aimed inside, on the
// edges of, and outside node boxes. A scoreboard keeps its own node table,
// predicts each locate walk and checks every response in order. The bench
// runs an empty-table phase, a directed phase and a long random phase with
// stalls on both channels.
// ----------------------------------------------------------------------------
module octree_point_locate_tb;
   import octpl_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 6;
   localparam int          PLAN_NODES   = 480;
   localparam int          RANDOM_ITEMS = 1280;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 400;
   localparam int          STALL_LIMIT  = 6000;
   localparam logic [31:0] CMIN = 32'h8000_0000;
   localparam logic [31:0] CMAX = 32'h7fff_ffff;

   typedef struct packed {
      logic      mode;
      node_type  node;
      point_type point;
   } octree_item_type;

   typedef struct packed {
      logic [FOUND_W-1:0]  found;
      logic [LEVELS_W-1:0] levels;
      status_type          status;
   } locate_result_type;

   typedef struct {
      int unsigned idx;
      int unsigned chain;
   } open_slot_type;

   class locate_checker;
      node_type          node_tbl[NODE_CAPACITY];
      int unsigned       fill;
      locate_result_type awaited[$];
      int unsigned       errors;
      int unsigned       appends;
      int unsigned       dropped;
      int unsigned       checked;
      int unsigned       deepest;
      int unsigned       status_seen[4];

      function new();
         fill    = 0;
         errors  = 0;
         appends = 0;
         dropped = 0;
         checked = 0;
         deepest = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function bit holds(node_type nd, point_type p);
         return ($signed(nd.low_x) <= $signed(p.x)) && ($signed(p.x) < $signed(nd.high_x)) &&
                ($signed(nd.low_y) <= $signed(p.y)) && ($signed(p.y) < $signed(nd.high_y)) &&
                ($signed(nd.low_z) <= $signed(p.z)) && ($signed(p.z) < $signed(nd.high_z));
      endfunction

      // walk from the root, taking the lowest octant whose box holds the point
      function locate_result_type walk_point(point_type p);
         locate_result_type r;
         int unsigned       cur;
         int unsigned       levels;
         int unsigned       base;
         int unsigned       below;
         int unsigned       child;
         logic [7:0]        m;
         bit                moved;
         r.status = STATUS_OK;
         if (fill == 0) begin
            r.found  = '0;
            r.levels = '0;
            r.status = STATUS_EMPTY;
            return r;
         end
         cur    = 0;
         levels = 0;
         forever begin
            m = node_tbl[cur].mask;
            if (m == 8'h00) break;
            if (levels >= MAX_LEVELS) begin
               r.status = STATUS_LIMIT;
               break;
            end
            base  = node_tbl[cur].first_child;
            below = 0;
            moved = 1'b0;
            for (int i = 0; i < 8; i++) begin
               if (m[i]) begin
                  child = base + below;
                  below++;
                  // children not yet appended never hold the point
                  if (child < fill && holds(node_tbl[child], p)) begin
                     cur   = child;
                     moved = 1'b1;
                     break;
                  end
               end
            end
            if (!moved) break;
            levels++;
         end
         r.found  = FOUND_W'(cur);
         r.levels = (levels > 31) ? 5'd31 : LEVELS_W'(levels);
         return r;
      endfunction

      function void note_request(octree_item_type it);
         if (it.mode == MODE_APPEND) begin
            if (fill < NODE_CAPACITY) begin
               node_tbl[fill] = it.node;
               fill++;
               appends++;
            end else begin
               dropped++;
            end
         end else begin
            awaited.insert(awaited.size(), walk_point(it.point));
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_result(locate_result_type got);
         locate_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected response node %0d levels %0d status %0d",
                                      got.found, got.levels, got.status));
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.found !== want.found || got.levels !== want.levels ||
             got.status !== want.status) begin
            report_mismatch($sformatf("got node %0d levels %0d status %0d, want %0d %0d %0d",
                                      got.found, got.levels, got.status,
                                      want.found, want.levels, want.status));
         end
         status_seen[want.status]++;
         if (want.levels > deepest) deepest = want.levels;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   bit   hold_rsp = 1'b0;

   node_type      plan[$];
   locate_checker board = new();

   octpl_req_if req_if();
   octpl_rsp_if rsp_if();

   octree_point_locate dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none during calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic node_type random_node();
      node_type nd;
      nd.mask        = 8'($urandom);
      nd.first_child = FC_W'($urandom);
      nd.low_x       = $urandom;
      nd.low_y       = $urandom;
      nd.low_z       = $urandom;
      nd.high_x      = $urandom;
      nd.high_y      = $urandom;
      nd.high_z      = $urandom;
      return nd;
   endfunction

   function automatic octree_item_type noise_item();
      octree_item_type it;
      it.mode    = MODE_APPEND;
      it.node    = random_node();
      it.point.x = $urandom;
      it.point.y = $urandom;
      it.point.z = $urandom;
      return it;
   endfunction

   function automatic octree_item_type make_append(node_type nd);
      octree_item_type it;
      it      = noise_item();
      it.mode = MODE_APPEND;
      it.node = nd;
      return it;
   endfunction

   function automatic octree_item_type make_locate(point_type p);
      octree_item_type it;
      it       = noise_item();
      it.mode  = MODE_LOCATE;
      it.point = p;
      return it;
   endfunction

   function automatic logic [31:0] coord_inside(logic [31:0] lo, logic [31:0] hi);
      longint          l;
      longint          h;
      longint unsigned r;
      l = $signed(lo);
      h = $signed(hi);
      if (h <= l) return $urandom;
      r = {$urandom, $urandom};
      return 32'(l + longint'(r % longint'(h - l)));
   endfunction

   function automatic logic [31:0] coord_edge(logic [31:0] lo, logic [31:0] hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi - 32'd1;
         2:       return hi;
         default: return lo - 32'd1;
      endcase
   endfunction

   function automatic logic [31:0] coord_extreme();
      case ($urandom_range(0, 3))
         0:       return CMIN;
         1:       return CMAX;
         2:       return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic point_type pick_point();
      point_type   p;
      node_type    nd;
      int unsigned r;
      r = $urandom_range(0, 99);
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
      if (board.fill == 0 || r < 15) return p;
      if (r < 20) begin
         p.x = coord_extreme();
         p.y = coord_extreme();
         p.z = coord_extreme();
         return p;
      end
      nd = board.node_tbl[$urandom_range(0, board.fill - 1)];
      if (r < 32) begin
         p.x = coord_edge(nd.low_x, nd.high_x);
         p.y = coord_edge(nd.low_y, nd.high_y);
         p.z = coord_edge(nd.low_z, nd.high_z);
      end else begin
         p.x = coord_inside(nd.low_x, nd.high_x);
         p.y = coord_inside(nd.low_y, nd.high_y);
         p.z = coord_inside(nd.low_z, nd.high_z);
      end
      return p;
   endfunction

   function automatic node_type octant_box(node_type par, int unsigned oct);
      node_type c;
      longint   lo;
      longint   hi;
      longint   mid;
      c             = par;
      c.mask        = '0;
      c.first_child = FC_W'($urandom);
      lo = $signed(par.low_x);
      hi = $signed(par.high_x);
      mid = lo + ((hi - lo) >>> 1);
      if (oct[0]) c.low_x = 32'(mid); else c.high_x = 32'(mid);
      lo = $signed(par.low_y);
      hi = $signed(par.high_y);
      mid = lo + ((hi - lo) >>> 1);
      if (oct[1]) c.low_y = 32'(mid); else c.high_y = 32'(mid);
      lo = $signed(par.low_z);
      hi = $signed(par.high_z);
      mid = lo + ((hi - lo) >>> 1);
      if (oct[2]) c.low_z = 32'(mid); else c.high_z = 32'(mid);
      return c;
   endfunction

   // Lay out the tree breadth first; children get contiguous indices after
   // their parent, so each append can open up deeper walks.
   function automatic void build_plan(int unsigned cap);
      open_slot_type open_q[$];
      open_slot_type cur;
      open_slot_type slot;
      node_type      nd;
      node_type      kid;
      int unsigned   r;
      int unsigned   q;
      plan.delete();
      nd             = '0;
      nd.low_x       = CMIN;
      nd.low_y       = CMIN;
      nd.low_z       = CMIN;
      nd.high_x      = CMAX;
      nd.high_y      = CMAX;
      nd.high_z      = CMAX;
      plan.insert(plan.size(), nd);
      slot.idx   = 0;
      slot.chain = 0;
      open_q.insert(open_q.size(), slot);
      while (open_q.size() > 0) begin
         cur = open_q.pop_front();
         nd  = plan[cur.idx];
         r   = (cur.idx == 0) ? 100 : $urandom_range(0, 99);
         if (cur.chain > 0 || (r >= 20 && r < 30)) begin
            // single child with the same box: long chains run into the level limit
            if (plan.size() < cap) begin
               nd.mask        = 8'(1 << $urandom_range(0, 7));
               nd.first_child = FC_W'(plan.size());
               kid             = nd;
               kid.mask        = '0;
               kid.first_child = FC_W'($urandom);
               plan.insert(plan.size(), kid);
               slot.idx   = plan.size() - 1;
               slot.chain = (cur.chain > 0) ? cur.chain - 1 : $urandom_range(2, 20);
               open_q.insert(open_q.size(), slot);
            end
         end else if (r >= 30 && r < 36) begin
            // point back into the tree to make a cycle
            nd.mask        = 8'($urandom_range(1, 255));
            nd.first_child = FC_W'($urandom_range(0, plan.size() - 1));
         end else if (r >= 36 && r < 40) begin
            // children far past the plan never enter the table
            nd.mask        = 8'($urandom_range(1, 255));
            nd.first_child = FC_W'($urandom_range(3000, NODE_CAPACITY - 1));
         end else if (r >= 40) begin
            nd.mask = (cur.idx == 0) ? 8'hff : 8'($urandom_range(1, 255));
            if (plan.size() + $countones(nd.mask) <= cap) begin
               nd.first_child = FC_W'(plan.size());
               for (int oct = 0; oct < 8; oct++) begin
                  if (nd.mask[oct]) begin
                     kid = octant_box(nd, oct);
                     q   = (cur.idx == 0) ? 100 : $urandom_range(0, 99);
                     if (q < 4) begin
                        kid.high_x = kid.low_x;
                     end else if (q < 8) begin
                        kid = random_node();
                        kid.mask = '0;
                     end else if (q < 12) begin
                        kid.low_x  = nd.low_x;
                        kid.low_y  = nd.low_y;
                        kid.low_z  = nd.low_z;
                        kid.high_x = nd.high_x;
                        kid.high_y = nd.high_y;
                        kid.high_z = nd.high_z;
                     end
                     plan.insert(plan.size(), kid);
                     slot.idx   = plan.size() - 1;
                     slot.chain = 0;
                     open_q.insert(open_q.size(), slot);
                  end
               end
            end else begin
               nd.mask = '0;
            end
         end
         plan[cur.idx] = nd;
      end
   endfunction

   task automatic put_fields(octree_item_type it);
      req_if.mode        <= it.mode;
      req_if.octant_mask <= it.node.mask;
      req_if.first_child <= it.node.first_child;
      req_if.low_x       <= it.node.low_x;
      req_if.low_y       <= it.node.low_y;
      req_if.low_z       <= it.node.low_z;
      req_if.high_x      <= it.node.high_x;
      req_if.high_y      <= it.node.high_y;
      req_if.high_z      <= it.node.high_z;
      req_if.point_x     <= it.point.x;
      req_if.point_y     <= it.point.y;
      req_if.point_z     <= it.point.z;
   endtask

   // present one transaction and hold it until accepted; valid stays high
   // when the next one follows without a gap
   task automatic send_item(octree_item_type it);
      int unsigned gap;
      req_if.valid <= 1'b1;
      put_fields(it);
      do @(posedge clock); while (req_if.ready !== 1'b1);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
   endtask

   always @(posedge clock) begin
      octree_item_type   seen;
      locate_result_type got;
      if (!reset && req_if.valid && req_if.ready) begin
         seen.mode             = req_if.mode;
         seen.node.mask        = req_if.octant_mask;
         seen.node.first_child = req_if.first_child;
         seen.node.low_x       = req_if.low_x;
         seen.node.low_y       = req_if.low_y;
         seen.node.low_z       = req_if.low_z;
         seen.node.high_x      = req_if.high_x;
         seen.node.high_y      = req_if.high_y;
         seen.node.high_z      = req_if.high_z;
         seen.point.x          = req_if.point_x;
         seen.point.y          = req_if.point_y;
         seen.point.z          = req_if.point_z;
         board.note_request(seen);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.found  = rsp_if.found_node;
         got.levels = rsp_if.levels_walked;
         got.status = status_type'(rsp_if.status);
         board.check_result(got);
      end
   end

   initial begin : rsp_stall
      int unsigned low_left;
      bit          hold_done;
      low_left  = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            low_left  = HOLD_CYCLES;
         end else if (low_left == 0 && $urandom_range(0, 2) == 0) begin
            low_left = pick_gap();
         end
         if (low_left > 0) begin
            low_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("octree_point_locate_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int unsigned next_node;
      int unsigned k;
      req_if.valid <= 1'b0;
      put_fields(octree_item_type'('0));
      build_plan(PLAN_NODES);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty table, then a root whose children are not in yet
      send_item(make_locate('{x: 32'h0, y: 32'h0, z: 32'h0}));
      send_item(make_locate('{x: CMIN, y: CMIN, z: CMIN}));
      send_item(make_locate('{x: CMAX, y: CMAX, z: CMAX}));
      send_item(make_append(plan[0]));
      send_item(make_locate('{x: 32'h0, y: 32'h0, z: 32'h0}));
      for (k = 1; k <= 8; k++) send_item(make_append(plan[k]));
      next_node = 9;
      // box corners: the high face is outside a box
      send_item(make_locate('{x: CMIN, y: CMIN, z: CMIN}));
      send_item(make_locate('{x: CMAX, y: CMAX, z: CMAX}));
      send_item(make_locate('{x: 32'hffff_ffff, y: 32'hffff_ffff, z: 32'hffff_ffff}));
      send_item(make_locate('{x: 32'hffff_fffe, y: 32'hffff_fffe, z: 32'hffff_fffe}));
      send_item(make_locate('{x: CMAX - 32'd1, y: CMIN, z: 32'h0}));
      send_item(make_locate('{x: 32'h0, y: 32'hffff_ffff, z: CMAX - 32'd1}));
      wait_drained();

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 50 == 0) calm = ($urandom_range(0, 4) == 0);
         if (k == 300) begin
            // stall the response side while requests keep coming
            hold_rsp = 1'b1;
            calm     = 1'b1;
         end
         if (k == 650) wait_drained();
         if (next_node < plan.size() && $urandom_range(0, 99) < 38) begin
            send_item(make_append(plan[next_node]));
            next_node++;
         end else begin
            send_item(make_locate(pick_point()));
         end
      end
      wait_drained();

      calm = 1'b0;
      repeat (16) send_item(make_locate(pick_point()));

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d appends (%0d dropped at full table), %0d locates checked.",
               board.appends, board.dropped, board.checked);
      $display("Status ok %0d, empty %0d, level limit %0d; deepest walk %0d; %0d errors.",
               board.status_seen[STATUS_OK], board.status_seen[STATUS_EMPTY],
               board.status_seen[STATUS_LIMIT], board.deepest, board.errors);
      if (board.errors == 0) begin
         $display("octree_point_locate_tb OK");
      end else begin
         $display("octree_point_locate_tb NOT OK");
      end
      $finish;
   end

endmodule
